// ===== design/flt_pkg.sv =====
// ----------------------------------------------------------------------------
// Floor lookup table package
// Shared types and constants for the sorted key/value table with floor search.
// ----------------------------------------------------------------------------
package flt_pkg;

   localparam int KEY_W          = 32;
   localparam int VALUE_W        = 32;
   localparam int STATUS_W       = 3;
   localparam int TREE_FANIN_LOG = 4;
   localparam int TREE_FANIN     = 1 << TREE_FANIN_LOG;

   // Operation carried in the request user field.
   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // Result status carried in the response user field.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_EXACT       = 3'd0,
      STATUS_EARLIER     = 3'd1,
      STATUS_NO_EARLIER  = 3'd2,
      STATUS_INSERTED    = 3'd3,
      STATUS_OVERWRITTEN = 3'd4,
      STATUS_FULL        = 3'd5
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_DECIDE
   } state_type;

   // Commands broadcast to every cell of the row.
   typedef struct packed {
      logic compare;
      logic overwrite;
      logic shift;
   } cell_cmd_type;

   // One node of the reduction tree.
   typedef struct packed {
      logic               any_eq;
      logic               any_le;
      logic [VALUE_W-1:0] value;
   } node_type;

endpackage

// ===== design/flt_cell.sv =====
// ----------------------------------------------------------------------------
// Table cell
// Holds one key/value entry, compares it against the broadcast key and shifts
// its contents one place up the row when a new key is inserted below it.
// ----------------------------------------------------------------------------
module flt_cell (
   input  logic                      clock,
   input  flt_pkg::cell_cmd_type     cmd,
   input  logic                      valid,
   input  logic [flt_pkg::KEY_W-1:0]   q_key,
   input  logic [flt_pkg::VALUE_W-1:0] q_value,
   input  logic [flt_pkg::KEY_W-1:0]   left_key,
   input  logic [flt_pkg::VALUE_W-1:0] left_value,
   input  logic                      left_le,
   input  logic                      right_le,
   output logic [flt_pkg::KEY_W-1:0]   key,
   output logic [flt_pkg::VALUE_W-1:0] value,
   output logic                      le,
   output flt_pkg::node_type         node
);
   import flt_pkg::*;

   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   key_in;
   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               le_ff;
   logic               le_in;
   logic               eq_ff;
   logic               eq_in;

   // Compare flags are captured once per item; the entry moves on insert.
   always_comb begin
      le_in    = le_ff;
      eq_in    = eq_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.compare) begin
         le_in = valid && (key_ff <= q_key);
         eq_in = valid && (key_ff == q_key);
      end
      if (cmd.overwrite && eq_ff) begin
         value_in = q_value;
      end
      // Cells above the insert point take their lower neighbor; the first
      // such cell takes the new entry.
      if (cmd.shift && !le_ff) begin
         if (left_le) begin
            key_in   = q_key;
            value_in = q_value;
         end else begin
            key_in   = left_key;
            value_in = left_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      le_ff    <= le_in;
      eq_ff    <= eq_in;
   end

   // The floor entry is the last cell whose key is not above the query.
   always_comb begin
      node.any_eq = eq_ff;
      node.any_le = le_ff;
      node.value  = (le_ff && !right_le) ? value_ff : '0;
   end

   assign key   = key_ff;
   assign value = value_ff;
   assign le    = le_ff;

endmodule

// ===== design/flt_or_tree.sv =====
// ----------------------------------------------------------------------------
// Registered reduction tree
// Combines the cell nodes with a registered OR tree, one level per cycle.
// ----------------------------------------------------------------------------
module flt_or_tree #(
   parameter int LEAVES = 1024,
   parameter int LEVELS = 3
) (
   input  logic              clock,
   input  flt_pkg::node_type leaf [LEAVES],
   output flt_pkg::node_type root
);
   import flt_pkg::*;

   node_type level_ff [LEVELS][LEAVES];
   node_type level_in [LEVELS][LEAVES];

   // Each node ORs up to TREE_FANIN children of the level below.
   always_comb begin
      node_type acc;
      for (int j = 0; j < LEAVES; j++) begin
         acc = '0;
         for (int k = 0; k < TREE_FANIN; k++) begin
            if (j * TREE_FANIN + k < LEAVES) begin
               acc = node_type'(acc | leaf[j * TREE_FANIN + k]);
            end
         end
         level_in[0][j] = acc;
      end
      for (int l = 1; l < LEVELS; l++) begin
         for (int j = 0; j < LEAVES; j++) begin
            acc = '0;
            for (int k = 0; k < TREE_FANIN; k++) begin
               if (j * TREE_FANIN + k < LEAVES) begin
                  acc = node_type'(acc | level_ff[l-1][j * TREE_FANIN + k]);
               end
            end
            level_in[l][j] = acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign root = level_ff[LEVELS-1][0];

endmodule

// ===== design/sorted_table_floor_lookup.sv =====
// ----------------------------------------------------------------------------
// Sorted table floor lookup
// Key/value table kept sorted in a row of cells, with insert and floor search.
// ----------------------------------------------------------------------------
// Every request beat is handled on its own: the request is loaded, every cell
// compares its key with the request key, the registered 16-way OR tree, whose
// depth is LEVELS = ceil(log2(TABLE_DEPTH) / 4), gathers the answer from the
// cells, and a decide step writes the response register. An insert moves all
// entries above the insert point up by one cell in that decide step, which
// waits while an earlier response is still held unaccepted. A finished
// response waits in its register, and the next request is taken while it
// waits. No clearing pass is needed after reset.
module sorted_table_floor_lookup #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] date_key, [63:32] rate_bits
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] found_rate
   output logic [2:0]  rsp_tuser    // [2:0] status
);
   import flt_pkg::*;

   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int LEVELS  = ($clog2(TABLE_DEPTH) + TREE_FANIN_LOG - 1) / TREE_FANIN_LOG;
   localparam int WAIT_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   state_type          state_ff;
   state_type          state_in;
   logic [WAIT_W-1:0]  wait_ff;
   logic [WAIT_W-1:0]  wait_in;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [COUNT_W-1:0] entry_count_in;
   op_type             q_op_ff;
   logic [KEY_W-1:0]   q_key_ff;
   logic [VALUE_W-1:0] q_value_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [VALUE_W-1:0] rsp_rate_ff;
   logic [VALUE_W-1:0] rsp_rate_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic               rsp_load;
   logic               req_accept;
   cell_cmd_type       cell_cmd;
   node_type           root;

   logic [KEY_W-1:0]   cell_key   [TABLE_DEPTH];
   logic [VALUE_W-1:0] cell_value [TABLE_DEPTH];
   logic               cell_le    [TABLE_DEPTH];
   node_type           cell_node  [TABLE_DEPTH];

   assign req_accept = req_tvalid && req_tready;

   // Row of cells; each one sees its neighbors on both sides.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0]   left_key;
      logic [VALUE_W-1:0] left_value;
      logic               left_le;
      logic               right_le;

      if (i == 0) begin : g_head
         assign left_key   = q_key_ff;
         assign left_value = q_value_ff;
         assign left_le    = 1'b1;
      end else begin : g_body
         assign left_key   = cell_key[i-1];
         assign left_value = cell_value[i-1];
         assign left_le    = cell_le[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign right_le = 1'b0;
      end else begin : g_inner
         assign right_le = cell_le[i+1];
      end

      flt_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .valid      (COUNT_W'(i) < entry_count_ff),
         .q_key      (q_key_ff),
         .q_value    (q_value_ff),
         .left_key   (left_key),
         .left_value (left_value),
         .left_le    (left_le),
         .right_le   (right_le),
         .key        (cell_key[i]),
         .value      (cell_value[i]),
         .le         (cell_le[i]),
         .node       (cell_node[i])
      );
   end

   // Gathers the floor value and hit flags from all cells.
   flt_or_tree #(
      .LEAVES (TABLE_DEPTH),
      .LEVELS (LEVELS)
   ) u_tree (
      .clock (clock),
      .leaf  (cell_node),
      .root  (root)
   );

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         q_op_ff    <= op_type'(req_tuser);
         q_key_ff   <= req_tdata[31:0];
         q_value_ff <= req_tdata[63:32];
      end
   end

   // Sequencer: next state, cell commands and response decision.
   always_comb begin
      state_in       = state_ff;
      wait_in        = wait_ff;
      entry_count_in = entry_count_ff;
      req_tready     = 1'b0;
      cell_cmd       = '0;
      rsp_load       = 1'b0;
      rsp_rate_in    = '0;
      rsp_status_in  = STATUS_NO_EARLIER;
      unique case (state_ff)
         ST_IDLE: begin
            // No beat is taken while reset is held.
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cell_cmd.compare = 1'b1;
            wait_in          = '0;
            state_in         = ST_REDUCE;
         end
         ST_REDUCE: begin
            wait_in = wait_ff + 1'b1;
            if (wait_ff == WAIT_W'(LEVELS - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
               if (q_op_ff == OP_LOOKUP) begin
                  if (!root.any_le) begin
                     rsp_status_in = STATUS_NO_EARLIER;
                  end else begin
                     rsp_rate_in   = root.value;
                     rsp_status_in = root.any_eq ? STATUS_EXACT : STATUS_EARLIER;
                  end
               end else if (root.any_eq) begin
                  cell_cmd.overwrite = 1'b1;
                  rsp_status_in      = STATUS_OVERWRITTEN;
               end else if (entry_count_ff == COUNT_W'(TABLE_DEPTH)) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  cell_cmd.shift = 1'b1;
                  entry_count_in = entry_count_ff + 1'b1;
                  rsp_status_in  = STATUS_INSERTED;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         wait_ff        <= '0;
         entry_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         wait_ff        <= wait_in;
         entry_count_ff <= entry_count_in;
      end
   end

   // Response register.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_rate_ff   <= rsp_rate_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rate_ff;
   assign rsp_tuser  = rsp_status_ff;

   // The entry count never passes the table depth.
   assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= COUNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   // The count only grows, by one, together with an inserted response.
   assert property (@(posedge clock) disable iff (reset)
      (entry_count_ff != $past(entry_count_ff)) |->
         (entry_count_ff == $past(entry_count_ff) + 1'b1) &&
         rsp_tvalid && (rsp_tuser == STATUS_INSERTED))
      else $error("entry count changed without an insert");

   // A full response is only given when the table is full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_FULL)) |->
         (entry_count_ff == COUNT_W'(TABLE_DEPTH)))
      else $error("full status with free entries");

   // Only lookup hits carry a value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_NO_EARLIER || rsp_tuser == STATUS_INSERTED ||
                      rsp_tuser == STATUS_OVERWRITTEN || rsp_tuser == STATUS_FULL))
         |-> (rsp_tdata == '0))
      else $error("value returned without a lookup hit");

endmodule
